[src/gbg_pkg.sv]
// shared constants, types and helper functions of the gaussian blur to gray block
// no dependencies; the interfaces, the cell and the top refer to this package by scoped names
package gbg_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_RADIUS  = 7;
  localparam int TAP_BITS    = 16;

  localparam int RING_ROWS   = 3 * MAX_RADIUS + 1;
  localparam int KERNEL_LEN  = 2 * MAX_RADIUS + 1;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS    = 13;
  localparam int RAD_BITS    = 3;
  localparam int TAPS_BITS   = 64;
  localparam int KIDX_BITS   = $clog2(KERNEL_LEN + 1);
  localparam int SLOT_BITS   = $clog2(RING_ROWS);
  localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
  localparam int RAM_DEPTH   = RING_ROWS * MAX_WIDTH;
  localparam int PIX_BITS    = 16;
  localparam int ONE_Q15     = 32768;
  localparam int PROD_BITS   = PIX_BITS + TAP_BITS;
  localparam int ACC_BITS    = PROD_BITS + $clog2(KERNEL_LEN + 1);
  localparam int LEAD_BITS   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int GRAY_BITS   = 8;

  // row modulo ring size by reciprocal multiply, one correction step
  localparam int RECIP_SHIFT = ROW_BITS + 5;
  localparam int RECIP       = (1 << RECIP_SHIFT) / RING_ROWS;
  localparam int Q_BITS      = $clog2(MAX_HEIGHT / RING_ROWS + 1);
  localparam int QPROD_BITS  = ROW_BITS + RECIP_SHIFT;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_BLUR_RADIUS   = 3'd2,
    REG_TAPS_LOW      = 3'd3,
    REG_TAPS_HIGH     = 3'd4,
    REG_INVERT_OUTPUT = 3'd5
  } cfg_reg_e;

  // partial vertical sum travelling along the cell chain
  typedef struct packed {
    logic                vld;
    logic [ACC_BITS-1:0] sum;
  } link_t;

  // position flags of one fetch in the kernel window
  typedef struct packed {
    logic                 first;
    logic                 last_row;
    logic                 last_all;
    logic [KIDX_BITS-1:0] dx;
  } fetch_tag_t;

  // round half up to q1.15 and saturate at one
  function automatic logic [PIX_BITS-1:0] normalize(logic [ACC_BITS-1:0] acc);
    logic [ACC_BITS:0] t;
    logic [ACC_BITS:0] v;
    t = {1'b0, acc} + (ACC_BITS+1)'(1 << (TAP_BITS - 1));
    v = t >> TAP_BITS;
    if (v > (ACC_BITS+1)'(ONE_Q15)) begin
      return PIX_BITS'(ONE_Q15);
    end
    return v[PIX_BITS-1:0];
  endfunction

  // weight of a kernel offset, offsets above seven weigh nothing
  function automatic logic [TAP_BITS-1:0] tap_at(logic [2*TAPS_BITS-1:0] taps,
                                                 logic [KIDX_BITS-1:0] off);
    if (off > KIDX_BITS'(7)) begin
      return '0;
    end
    return taps[off[2:0]*TAP_BITS +: TAP_BITS];
  endfunction

  // weight of kernel position j for radius r, zero past the window
  function automatic logic [TAP_BITS-1:0] kernel_weight(logic [2*TAPS_BITS-1:0] taps,
                                                        logic [RAD_BITS-1:0] r,
                                                        logic [KIDX_BITS-1:0] j);
    logic [KIDX_BITS-1:0] rr;
    logic [KIDX_BITS-1:0] off;
    rr  = KIDX_BITS'(r);
    off = (j >= rr) ? j - rr : rr - j;
    if (j > {rr[KIDX_BITS-2:0], 1'b0}) begin
      return '0;
    end
    return tap_at(taps, off);
  endfunction

endpackage

[src/gbg_in_if.sv]
// input channel of the blur block: coverage pixels and drain ticks
// uses gbg_pkg for field widths
interface gbg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [gbg_pkg::PIX_BITS-1:0]  coverage_in;

  modport source (output valid, output opcode, output coverage_in, input ready);
  modport sink   (input valid, input opcode, input coverage_in, output ready);
endinterface

[src/gbg_out_if.sv]
// output channel of the blur block: gray bytes with end of frame mark
// uses gbg_pkg for field widths
interface gbg_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbg_pkg::GRAY_BITS-1:0] gray_out;
  logic                          frame_end;

  modport source (output valid, output gray_out, output frame_end, input ready);
  modport sink   (input valid, input gray_out, input frame_end, output ready);
endinterface

[src/gbg_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module gbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gbg_cell.sv]
// one cell of the vertical kernel chain: holds a row result, adds its weighted term
// uses gbg_pkg for widths and the link type
module gbg_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [gbg_pkg::PIX_BITS-1:0]  h_i,
  output logic [gbg_pkg::PIX_BITS-1:0]  h_o,
  input  logic [gbg_pkg::TAP_BITS-1:0]  weight_i,
  input  gbg_pkg::link_t                link_i,
  output gbg_pkg::link_t                link_o
);

  logic [gbg_pkg::PIX_BITS-1:0]  h_q;
  logic [gbg_pkg::PROD_BITS-1:0] prod;
  gbg_pkg::link_t                link_q;

  // row results shift along the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else if (shift_i) begin
      h_q <= h_i;
    end
  end

  assign prod = gbg_pkg::PROD_BITS'(weight_i) * gbg_pkg::PROD_BITS'(h_q);

  // partial sum picks up this cell's term and moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q.vld <= link_i.vld;
      link_q.sum <= link_i.sum + gbg_pkg::ACC_BITS'(prod);
    end
  end

  assign h_o    = h_q;
  assign link_o = link_q;

endmodule

[src/separable_gaussian_blur_to_gray_top.sv]
// top level of the separable gaussian blur to gray block
// depends on gbg_pkg, gbg_in_if, gbg_out_if, gbg_ram and gbg_cell
//
// usage
// pix_i takes words in raster order: opcode 0 carries a q1.15 coverage pixel,
// opcode 1 is a drain tick. res_o returns gray bytes, frame_end marks the last one.
// output k leaves once input k + radius*width + radius is in; after the frame
// is complete every accepted word, drain or pixel, releases one tail output.
// cfg_we_i / cfg_idx_i / cfg_data_i write the registers, only while idle.
// a word that releases an output fetches the (2R+1)^2 window from the row ring,
// one read per cycle, then ripples the vertical sum through a chain of 15
// cells, and pix_i.ready stays low until the byte sits in the output register.
// the row ring has a single read port. a waiting output does not block the next
// word; only the next output waits for res_o.ready. reset clears counters and
// config (width 1, height 1, radius 0); the row ring needs no clearing, unwritten
// rows are never read.
module separable_gaussian_blur_to_gray_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [gbg_pkg::TAPS_BITS-1:0]  cfg_data_i,
  gbg_in_if.sink                         pix_i,
  gbg_out_if.source                      res_o
);

  localparam int KL = gbg_pkg::KERNEL_LEN;

  // configuration registers
  logic [gbg_pkg::DIM_BITS-1:0]   width_q, height_q;
  logic [gbg_pkg::RAD_BITS-1:0]   radius_q;
  logic [gbg_pkg::TAPS_BITS-1:0]  taps_lo_q, taps_hi_q;
  logic                           invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= gbg_pkg::DIM_BITS'(1);
      height_q  <= gbg_pkg::DIM_BITS'(1);
      radius_q  <= '0;
      taps_lo_q <= '0;
      taps_hi_q <= '0;
      invert_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (gbg_pkg::cfg_reg_e'(cfg_idx_i))
        gbg_pkg::REG_FRAME_WIDTH:   width_q   <= cfg_data_i[gbg_pkg::DIM_BITS-1:0];
        gbg_pkg::REG_FRAME_HEIGHT:  height_q  <= cfg_data_i[gbg_pkg::DIM_BITS-1:0];
        gbg_pkg::REG_BLUR_RADIUS:   radius_q  <= cfg_data_i[gbg_pkg::RAD_BITS-1:0];
        gbg_pkg::REG_TAPS_LOW:      taps_lo_q <= cfg_data_i;
        gbg_pkg::REG_TAPS_HIGH:     taps_hi_q <= cfg_data_i;
        gbg_pkg::REG_INVERT_OUTPUT: invert_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective frame size and radius
  logic [gbg_pkg::DIM_BITS-1:0]   w_eff, h_eff, w_last, h_last;
  logic [gbg_pkg::RAD_BITS-1:0]   r_eff;
  logic [gbg_pkg::LEAD_BITS-1:0]  lag;
  logic [2*gbg_pkg::TAPS_BITS-1:0] taps;
  logic [gbg_pkg::KIDX_BITS-1:0]  k_last;

  always_comb begin
    w_eff = (width_q == '0) ? gbg_pkg::DIM_BITS'(1) :
            (width_q > gbg_pkg::DIM_BITS'(gbg_pkg::MAX_WIDTH)) ?
            gbg_pkg::DIM_BITS'(gbg_pkg::MAX_WIDTH) : width_q;
    h_eff = (height_q == '0) ? gbg_pkg::DIM_BITS'(1) :
            (height_q > gbg_pkg::DIM_BITS'(gbg_pkg::MAX_HEIGHT)) ?
            gbg_pkg::DIM_BITS'(gbg_pkg::MAX_HEIGHT) : height_q;
    r_eff = (radius_q > gbg_pkg::RAD_BITS'(gbg_pkg::MAX_RADIUS)) ?
            gbg_pkg::RAD_BITS'(gbg_pkg::MAX_RADIUS) : radius_q;
    w_last = w_eff - gbg_pkg::DIM_BITS'(1);
    h_last = h_eff - gbg_pkg::DIM_BITS'(1);
    lag = gbg_pkg::LEAD_BITS'(gbg_pkg::LEAD_BITS'(r_eff) * gbg_pkg::LEAD_BITS'(w_eff)
          + gbg_pkg::LEAD_BITS'(r_eff));
    taps = {taps_hi_q, taps_lo_q};
    k_last = gbg_pkg::KIDX_BITS'({1'b0, r_eff, 1'b0});
  end

  // frame counters
  logic [gbg_pkg::COL_BITS-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [gbg_pkg::DIM_BITS-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [gbg_pkg::SLOT_BITS-1:0]  in_slot_q, in_slot_d;
  logic [gbg_pkg::LEAD_BITS-1:0]  lead_q, lead_d;
  logic [gbg_pkg::DIM_BITS-1:0]   in_col_inc, out_col_inc;
  logic [gbg_pkg::DIM_BITS:0]     out_row_inc;
  logic                           busy_q;
  logic                           acc_in, complete, store, emit, out_last;
  logic [gbg_pkg::PIX_BITS-1:0]   cov_clamped;

  assign pix_i.ready = !busy_q;
  assign acc_in      = pix_i.valid && !busy_q;
  assign complete    = in_row_q >= h_eff;
  assign store       = !complete && !pix_i.opcode;
  assign emit        = complete || (!pix_i.opcode && lead_q >= lag);
  assign in_col_inc  = gbg_pkg::DIM_BITS'(in_col_q) + gbg_pkg::DIM_BITS'(1);
  assign out_col_inc = gbg_pkg::DIM_BITS'(out_col_q) + gbg_pkg::DIM_BITS'(1);
  assign out_row_inc = {1'b0, out_row_q} + (gbg_pkg::DIM_BITS+1)'(1);
  assign out_last    = (out_col_inc >= w_eff) && (out_row_inc >= {1'b0, h_eff});
  assign cov_clamped = (pix_i.coverage_in > gbg_pkg::PIX_BITS'(gbg_pkg::ONE_Q15)) ?
                       gbg_pkg::PIX_BITS'(gbg_pkg::ONE_Q15) : pix_i.coverage_in;

  // next counter values
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_slot_d = in_slot_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    if (acc_in && store) begin
      if (in_col_inc >= w_eff) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + gbg_pkg::DIM_BITS'(1);
        in_slot_d = (in_slot_q == gbg_pkg::SLOT_BITS'(gbg_pkg::RING_ROWS - 1)) ? '0 :
                    in_slot_q + gbg_pkg::SLOT_BITS'(1);
      end else begin
        in_col_d = in_col_inc[gbg_pkg::COL_BITS-1:0];
      end
      if (!emit) begin
        lead_d = lead_q + gbg_pkg::LEAD_BITS'(1);
      end
    end
    if (acc_in && emit) begin
      if (out_last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        in_slot_d = '0;
        out_col_d = '0;
        out_row_d = '0;
        lead_d    = '0;
      end else if (out_col_inc >= w_eff) begin
        out_col_d = '0;
        out_row_d = out_row_q + gbg_pkg::DIM_BITS'(1);
      end else begin
        out_col_d = out_col_inc[gbg_pkg::COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_slot_q <= in_slot_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  // window sequencer: walks dy rows and dx columns of the kernel
  logic                            iss_q;
  logic [gbg_pkg::KIDX_BITS-1:0]   dy_q, dx_q;
  logic [gbg_pkg::COL_BITS-1:0]    x_q;
  logic [gbg_pkg::ROW_BITS-1:0]    y_q;
  logic                            last_q;
  logic                            move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q  <= 1'b0;
      busy_q <= 1'b0;
      dy_q   <= '0;
      dx_q   <= '0;
      last_q <= 1'b0;
    end else begin
      if (acc_in && emit) begin
        iss_q  <= 1'b1;
        busy_q <= 1'b1;
        dy_q   <= '0;
        dx_q   <= '0;
        last_q <= out_last;
      end else begin
        if (move) begin
          busy_q <= 1'b0;
        end
        if (iss_q) begin
          if (dx_q == k_last) begin
            dx_q <= '0;
            if (dy_q == k_last) begin
              iss_q <= 1'b0;
            end else begin
              dy_q <= dy_q + gbg_pkg::KIDX_BITS'(1);
            end
          end else begin
            dx_q <= dx_q + gbg_pkg::KIDX_BITS'(1);
          end
        end
      end
    end
  end

  // output position clamped into the frame
  always_ff @(posedge clk_i) begin
    if (acc_in && emit) begin
      x_q <= (gbg_pkg::DIM_BITS'(out_col_q) > w_last) ? w_last[gbg_pkg::COL_BITS-1:0]
                                                      : out_col_q;
      y_q <= (out_row_q > h_last) ? h_last[gbg_pkg::ROW_BITS-1:0]
                                  : out_row_q[gbg_pkg::ROW_BITS-1:0];
    end
  end

  // stage 1: clamped row and column of this fetch
  logic [gbg_pkg::DIM_BITS-1:0]  t_row, t_col, lo_row, lo_col, rad_d;
  logic                          s1_vld_q;
  logic [gbg_pkg::ROW_BITS-1:0]  s1_row_q;
  logic [gbg_pkg::COL_BITS-1:0]  s1_col_q;
  gbg_pkg::fetch_tag_t           s1_tag_q, s1_tag;

  always_comb begin
    rad_d  = gbg_pkg::DIM_BITS'(r_eff);
    t_row  = gbg_pkg::DIM_BITS'(y_q) + gbg_pkg::DIM_BITS'(dy_q);
    t_col  = gbg_pkg::DIM_BITS'(x_q) + gbg_pkg::DIM_BITS'(dx_q);
    lo_row = (t_row < rad_d) ? '0 : t_row - rad_d;
    lo_col = (t_col < rad_d) ? '0 : t_col - rad_d;
    lo_row = (lo_row > h_last) ? h_last : lo_row;
    lo_col = (lo_col > w_last) ? w_last : lo_col;
    s1_tag.first    = (dx_q == '0);
    s1_tag.last_row = (dx_q == k_last);
    s1_tag.last_all = (dx_q == k_last) && (dy_q == k_last);
    s1_tag.dx       = dx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= iss_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= lo_row[gbg_pkg::ROW_BITS-1:0];
    s1_col_q <= lo_col[gbg_pkg::COL_BITS-1:0];
    s1_tag_q <= s1_tag;
  end

  // stage 2: quotient of row by ring size
  logic [gbg_pkg::QPROD_BITS-1:0] qprod;
  logic                           s2_vld_q;
  logic [gbg_pkg::ROW_BITS-1:0]   s2_row_q;
  logic [gbg_pkg::COL_BITS-1:0]   s2_col_q;
  logic [gbg_pkg::Q_BITS-1:0]     s2_q_q;
  gbg_pkg::fetch_tag_t            s2_tag_q;

  assign qprod = gbg_pkg::QPROD_BITS'(s1_row_q) * gbg_pkg::QPROD_BITS'(gbg_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_row_q <= s1_row_q;
    s2_col_q <= s1_col_q;
    s2_q_q   <= qprod[gbg_pkg::RECIP_SHIFT +: gbg_pkg::Q_BITS];
    s2_tag_q <= s1_tag_q;
  end

  // stage 3: ring slot and row ring read
  logic [gbg_pkg::ROW_BITS-1:0]   rem;
  logic [gbg_pkg::SLOT_BITS-1:0]  slot;
  logic [gbg_pkg::PIX_BITS-1:0]   rdata;
  logic                           s3_vld_q;
  gbg_pkg::fetch_tag_t            s3_tag_q;

  always_comb begin
    rem  = s2_row_q - gbg_pkg::ROW_BITS'(s2_q_q * gbg_pkg::RING_ROWS);
    slot = (rem >= gbg_pkg::ROW_BITS'(gbg_pkg::RING_ROWS)) ?
           gbg_pkg::SLOT_BITS'(rem - gbg_pkg::ROW_BITS'(gbg_pkg::RING_ROWS)) :
           gbg_pkg::SLOT_BITS'(rem);
  end

  gbg_ram #(
    .WIDTH (gbg_pkg::PIX_BITS),
    .DEPTH (gbg_pkg::RAM_DEPTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (acc_in && store),
    .waddr_i ({in_slot_q, in_col_q}),
    .wdata_i (cov_clamped),
    .re_i    (s2_vld_q),
    .raddr_i ({slot, s2_col_q}),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_tag_q <= s2_tag_q;
  end

  // stage 4: weighted pixel
  logic [gbg_pkg::TAP_BITS-1:0]   hw;
  logic [gbg_pkg::KIDX_BITS-1:0]  rr_k, hoff;
  logic                           s4_vld_q;
  logic [gbg_pkg::PROD_BITS-1:0]  prod_q;
  logic [gbg_pkg::PIX_BITS-1:0]   raw_q;
  gbg_pkg::fetch_tag_t            s4_tag_q;

  always_comb begin
    rr_k = gbg_pkg::KIDX_BITS'(r_eff);
    hoff = (s3_tag_q.dx >= rr_k) ? s3_tag_q.dx - rr_k : rr_k - s3_tag_q.dx;
    hw   = gbg_pkg::tap_at(taps, hoff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= gbg_pkg::PROD_BITS'(hw) * gbg_pkg::PROD_BITS'(rdata);
    raw_q    <= rdata;
    s4_tag_q <= s3_tag_q;
  end

  // stage 5: horizontal accumulate, row result shifts into the cell chain
  logic [gbg_pkg::ACC_BITS-1:0]   acc_q, acc_new;
  logic [gbg_pkg::PIX_BITS-1:0]   h_new;
  logic                           push, bypass_done, rip_go_q;

  assign acc_new = s4_tag_q.first ? gbg_pkg::ACC_BITS'(prod_q)
                                  : acc_q + gbg_pkg::ACC_BITS'(prod_q);
  assign h_new       = gbg_pkg::normalize(acc_new);
  assign push        = s4_vld_q && s4_tag_q.last_row && (r_eff != '0);
  assign bypass_done = s4_vld_q && s4_tag_q.last_all && (r_eff == '0);

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      acc_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rip_go_q <= 1'b0;
    end else begin
      rip_go_q <= s4_vld_q && s4_tag_q.last_all && (r_eff != '0);
    end
  end

  // vertical pass: chain of cells, sum ripples from cell 0 to the end
  logic [gbg_pkg::PIX_BITS-1:0]  cell_h    [KL+1];
  gbg_pkg::link_t                cell_link [KL+1];

  assign cell_h[0]        = h_new;
  assign cell_link[0].vld = rip_go_q;
  assign cell_link[0].sum = '0;

  for (genvar j = 0; j < KL; j++) begin : g_cell
    gbg_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (push),
      .h_i      (cell_h[j]),
      .h_o      (cell_h[j+1]),
      .weight_i (gbg_pkg::kernel_weight(taps, r_eff, gbg_pkg::KIDX_BITS'(j))),
      .link_i   (cell_link[j]),
      .link_o   (cell_link[j+1])
    );
  end

  // finished blur value waiting for the output register
  logic                          fin_vld_q;
  logic [gbg_pkg::PIX_BITS-1:0]  fin_v_q;

  assign move = fin_vld_q && (!res_o.valid || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (bypass_done || cell_link[KL].vld) begin
      fin_vld_q <= 1'b1;
    end else if (move) begin
      fin_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bypass_done) begin
      fin_v_q <= raw_q;
    end else if (cell_link[KL].vld) begin
      fin_v_q <= gbg_pkg::normalize(cell_link[KL].sum);
    end
  end

  // invert and convert to gray byte
  logic [gbg_pkg::PIX_BITS-1:0]  v_fin;
  logic [gbg_pkg::PIX_BITS+7:0]  gray_wide;
  logic                          out_vld_q, fend_q;
  logic [gbg_pkg::GRAY_BITS-1:0] gray_q;

  always_comb begin
    v_fin = invert_q ? gbg_pkg::PIX_BITS'(gbg_pkg::ONE_Q15) - fin_v_q : fin_v_q;
    gray_wide = (gbg_pkg::PIX_BITS+8)'(v_fin) * (gbg_pkg::PIX_BITS+8)'(255)
              + (gbg_pkg::PIX_BITS+8)'(16384);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      gray_q <= gray_wide[15 +: gbg_pkg::GRAY_BITS];
      fend_q <= last_q;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.gray_out  = gray_q;
  assign res_o.frame_end = fend_q;

endmodule
